FILE: rtl/vkhp_pkg.sv
// Shared types and constants for the VP9 key frame header parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package vkhp_pkg;

	// Only the first ten bytes hold bits the parse can ever reach (76 bits at most).
	localparam int STORE_BYTES = 10;
	localparam int HDR_W       = STORE_BYTES * 8;
	localparam int POS_W       = $clog2(HDR_W);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_MARK  = 3'd2;
	localparam logic [2:0] ST_RESERVED  = 3'd3;
	localparam logic [2:0] ST_NOT_KEY   = 3'd4;
	localparam logic [2:0] ST_BAD_SYNC  = 3'd5;

	localparam logic [1:0]  FRAME_MARKER = 2'h2;
	localparam logic [1:0]  PROFILE_3    = 2'd3;
	localparam logic [23:0] SYNC_CODE    = 24'h498342;
	localparam logic [2:0]  CS_RGB       = 3'd7;

	// One queued transaction: either a gathered header or a too-short notice.
	typedef struct packed {
		logic             too_short;
		logic [HDR_W-1:0] hdr;
	} job_t;

endpackage

FILE: rtl/vkhp_front.sv
// Front end: accepts frame bytes, gathers the header bytes and decides when
// a frame needs a result. Depends on vkhp_pkg.
`timescale 1ns / 1ps

module vkhp_front #(
	parameter int HEADER_BYTES = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               push,
	output vkhp_pkg::job_t     job
);

	localparam int SEEN_W = $clog2(HEADER_BYTES);

	logic [SEEN_W-1:0]          seen_q;
	logic                       given_q;
	logic [vkhp_pkg::HDR_W-1:0] hdr_q;
	logic [vkhp_pkg::HDR_W-1:0] hdr_next;
	logic [SEEN_W:0]            cnt;
	logic                       complete;

	assign cnt      = {1'b0, seen_q} + {{SEEN_W{1'b0}}, 1'b1};
	assign complete = (cnt >= (SEEN_W+1)'(HEADER_BYTES));

	always_comb begin
		hdr_next = hdr_q;
		for (int i = 0; i < vkhp_pkg::STORE_BYTES; i++) begin
			if (seen_q == SEEN_W'(i))
				hdr_next[vkhp_pkg::HDR_W-1-8*i -: 8] = data_byte;
		end
	end

	assign push          = accept && !given_q && (complete || last_byte);
	assign job.too_short = !complete;
	assign job.hdr       = hdr_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			given_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				seen_q  <= '0;
				given_q <= 1'b0;
			end else if (!given_q) begin
				if (complete)
					given_q <= 1'b1;
				else
					seen_q <= cnt[SEEN_W-1:0];
			end
		end
	end

	// every stored header byte (the first STORE_BYTES) is written before the parse reads it
	always_ff @(posedge clk) begin
		if (accept && !given_q)
			hdr_q <= hdr_next;
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> seen_q == '0 && !given_q)
		else $error("frame state not cleared after last byte");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		given_q |-> !push)
		else $error("second result pushed for one frame");

endmodule

FILE: rtl/vkhp_queue.sv
// Two-entry queue of header jobs between the front and back ends.
// Depends on vkhp_pkg.
`timescale 1ns / 1ps

module vkhp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vkhp_pkg::job_t wr_job,
	input  logic           pop,
	output vkhp_pkg::job_t rd_job,
	output logic           empty,
	output logic           full
);

	localparam int CNT_W = $clog2(vkhp_pkg::QUEUE_DEPTH + 1);
	localparam int PTR_W = $clog2(vkhp_pkg::QUEUE_DEPTH);

	vkhp_pkg::job_t    mem_q [vkhp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(vkhp_pkg::QUEUE_DEPTH));
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

endmodule

FILE: rtl/vkhp_back.sv
// Back end: parses a queued header and holds the result in the output register.
// Depends on vkhp_pkg.
`timescale 1ns / 1ps

module vkhp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  vkhp_pkg::job_t job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     status,
	output logic           type_known,
	output logic           frame_type,
	output logic [16:0]    frame_width,
	output logic [16:0]    frame_height
);

	localparam int W  = vkhp_pkg::HDR_W;
	localparam int PW = vkhp_pkg::POS_W;

	logic            out_valid_q;
	logic [2:0]      status_q;
	logic            type_known_q;
	logic            frame_type_q;
	logic [16:0]     width_q;
	logic [16:0]     height_q;

	logic [2:0]      p_status;
	logic            p_known;
	logic            p_type;
	logic [16:0]     p_width;
	logic [16:0]     p_height;

	always_comb begin
		logic [1:0]    profile;
		logic          odd;
		logic [PW-1:0] p1, p2, p3, p4;
		logic [W-1:0]  t1, t2, t3, t4;
		logic          rsv_color;
		logic [2:0]    color;

		profile = {job.hdr[W-4], job.hdr[W-3]};
		odd     = profile[0];
		p1      = (profile == vkhp_pkg::PROFILE_3) ? PW'(5) : PW'(4);
		t1      = job.hdr << p1;
		// show_existing_frame carries a 3-bit index
		p2      = p1 + (t1[W-1] ? PW'(4) : PW'(1));
		t2      = job.hdr << p2;
		// frame type, show_frame, error_resilient, then sync code and, in profiles 2 and 3, the bit-depth bit
		p3      = p2 + PW'(27) + (profile[1] ? PW'(1) : PW'(0));
		t3      = job.hdr << p3;
		color   = t3[W-1 -: 3];
		if (color != vkhp_pkg::CS_RGB) begin
			rsv_color = odd && t3[W-7];
			p4        = p3 + (odd ? PW'(7) : PW'(4));
		end else begin
			rsv_color = odd && t3[W-4];
			p4        = p3 + (odd ? PW'(4) : PW'(3));
		end
		t4 = job.hdr << p4;

		p_status = vkhp_pkg::ST_OK;
		p_known  = 1'b0;
		p_type   = 1'b0;
		p_width  = '0;
		p_height = '0;
		priority if (job.too_short) begin
			p_status = vkhp_pkg::ST_SHORT;
		end else if (job.hdr[W-1 -: 2] != vkhp_pkg::FRAME_MARKER) begin
			p_status = vkhp_pkg::ST_BAD_MARK;
		end else if (profile == vkhp_pkg::PROFILE_3 && job.hdr[W-5]) begin
			p_status = vkhp_pkg::ST_RESERVED;
		end else begin
			p_known = 1'b1;
			p_type  = t2[W-1];
			priority if (t2[W-1]) begin
				p_status = vkhp_pkg::ST_NOT_KEY;
			end else if (t2[W-4 -: 24] != vkhp_pkg::SYNC_CODE) begin
				p_status = vkhp_pkg::ST_BAD_SYNC;
			end else if (rsv_color) begin
				p_status = vkhp_pkg::ST_RESERVED;
			end else begin
				p_width  = {1'b0, t4[W-1 -: 16]} + 17'd1;
				p_height = {1'b0, t4[W-17 -: 16]} + 17'd1;
			end
		end
	end

	assign pop = job_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q     <= p_status;
			type_known_q <= p_known;
			frame_type_q <= p_type;
			width_q      <= p_width;
			height_q     <= p_height;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign type_known   = type_known_q;
	assign frame_type   = frame_type_q;
	assign frame_width  = width_q;
	assign frame_height = height_q;

	a_ok_has_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == vkhp_pkg::ST_OK |-> width_q != '0 && height_q != '0)
		else $error("key frame result without size");

	a_short_no_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == vkhp_pkg::ST_SHORT |-> !type_known_q)
		else $error("too-short result reports a frame type");

endmodule

FILE: rtl/vp9_keyframe_header_parser.sv
// VP9 key frame header parser, top level: front end, job queue, back end.
// Depends on vkhp_pkg, vkhp_front, vkhp_queue, vkhp_back.
//
// Input channel (in_valid/in_ready): one byte of a compressed frame per
// transaction, data_byte plus last_byte on the final byte of the frame.
// Output channel (out_valid/out_ready): at most one result per frame, with
// status, type_known, frame_type, frame_width and frame_height.
// A result is produced on the HEADER_BYTES-th byte of a frame, or with
// status "too short" on a last byte that comes earlier; bytes after the
// result are dropped until the last byte, which starts a new frame.
// Throughput: one byte per cycle while the queue is not full. The job enters
// the queue on the accepting edge and is parsed into the output register
// when it is popped, which waits while a held result is not yet taken.
// When the receiver stalls, the held result and the queue absorb up to
// three results; then in_ready drops until the output drains.
// Reset clears the frame byte count, the queue and the output valid; no
// clearing pass is needed, so bytes are taken from the first cycle on.
`timescale 1ns / 1ps

module vp9_keyframe_header_parser #(
	parameter int HEADER_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        type_known,
	output logic        frame_type,
	output logic [16:0] frame_width,
	output logic [16:0] frame_height
);

	logic           accept;
	logic           push;
	logic           pop;
	logic           q_empty;
	logic           q_full;
	vkhp_pkg::job_t wr_job;
	vkhp_pkg::job_t rd_job;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	vkhp_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.push     (push),
		.job      (wr_job)
	);

	vkhp_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(wr_job),
		.pop   (pop),
		.rd_job(rd_job),
		.empty (q_empty),
		.full  (q_full)
	);

	vkhp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (!q_empty),
		.job         (rd_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.type_known  (type_known),
		.frame_type  (frame_type),
		.frame_width (frame_width),
		.frame_height(frame_height)
	);

endmodule
